// ===== sv/publish_subscribe_fanout_table_core_assert.svh =====
// Assertion macros shared by the checker of the fan-out table core.
`ifndef PUBLISH_SUBSCRIBE_FANOUT_TABLE_CORE_ASSERT_SVH
`define PUBLISH_SUBSCRIBE_FANOUT_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/psft_pkg.sv =====
// Types and constants shared by the fan-out table core modules.
`timescale 1ns / 1ps
package psft_pkg;

	localparam int SIGNAL_DEPTH = 64;
	localparam int ADDR_W       = $clog2(SIGNAL_DEPTH);
	localparam int SIG_W        = 6;
	localparam int PRIO_W       = 5;
	localparam int MASK_W       = 32;
	localparam int LIMIT_W      = 7;
	localparam int CFG_IDX_W    = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic [SIG_W-1:0]   FIRST_RESET = 6'd4;

	typedef enum logic [1:0] {
		ACT_SUB   = 2'd0,
		ACT_UNSUB = 2'd1,
		ACT_PUB   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIGNAL_LIMIT = 2'd0,
		REG_FIRST_USER   = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WALK
	} state_t;

	// Result of the shared bit unit.
	typedef struct packed {
		logic [MASK_W-1:0] new_mask;
		logic [PRIO_W-1:0] top_idx;
		logic              rest_zero;
		logic              any;
	} bitop_res_t;

endpackage

// ===== sv/psft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module psft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/psft_bitop.sv =====
// Shared bit unit: sets or clears a mask bit, or finds and strips the top set bit.
`timescale 1ns / 1ps
module psft_bitop import psft_pkg::*; (
	input  logic [MASK_W-1:0] mask,
	input  action_t           op,
	input  logic [PRIO_W-1:0] index,
	output bitop_res_t        res
);

	// Upper half of each shrinking window, used by the binary leading-one search.
	localparam logic [MASK_W-1:0] HALF_MASK [PRIO_W] = '{
		32'h0000_0002, 32'h0000_000C, 32'h0000_00F0, 32'h0000_FF00, 32'hFFFF_0000
	};

	logic [MASK_W-1:0] v;
	logic [PRIO_W-1:0] idx;
	logic [MASK_W-1:0] one_hot_req;
	logic [MASK_W-1:0] one_hot_top;
	logic [MASK_W-1:0] stripped;

	always_comb begin
		v   = mask;
		idx = '0;
		for (int l = PRIO_W - 1; l >= 0; l--) begin
			if (|(v & HALF_MASK[l])) begin
				idx[l] = 1'b1;
				v      = v >> (1 << l);
			end
		end
	end

	assign one_hot_req = MASK_W'(1) << index;
	assign one_hot_top = MASK_W'(1) << idx;
	assign stripped    = mask & ~one_hot_top;

	always_comb begin
		res.top_idx   = idx;
		res.rest_zero = ~|stripped;
		res.any       = |mask;
		case (op)
			ACT_SUB:   res.new_mask = mask | one_hot_req;
			ACT_UNSUB: res.new_mask = mask & ~one_hot_req;
			ACT_PUB:   res.new_mask = stripped;
			default:   res.new_mask = mask;
		endcase
	end

endmodule

// ===== sv/publish_subscribe_fanout_table_core.sv =====
// Top level of the publish/subscribe fan-out table core.
//
// The block keeps one 32-bit subscriber mask per signal number. A command word is
// accepted at a rising edge where start is high and busy is low; it carries action,
// signal and priority_req. Subscribe sets the priority's bit in the signal's mask,
// unsubscribe clears it, and neither gives a result when it succeeds. Publish gives
// one result word per subscribed priority, highest first, with last on the final
// one; a publish with an empty mask gives nothing, and the mask is left unchanged.
// A signal below first_user_signal, at or above signal_limit, or a priority of zero
// on subscribe or unsubscribe gives a single result word with error and last set.
// Action three is taken and ignored.
// Timing: a rejected command shows its error word in the cycle after acceptance and
// busy never rises. Subscribe and unsubscribe read the table, then write the mask
// back. Publish reads the table and then walks the mask, one subscriber per word;
// the registered table read data and then the output registers lie between
// acceptance and the first word, and the words come out on consecutive cycles. The
// rate is set by the shared bit unit, which strips one mask bit per cycle. Each
// result word is on the outputs for exactly one cycle marked by strobe; there is
// no back pressure. Configuration words on the cfg channel are always ready and
// must be written while the block is idle.
// Reset clears every mask through per-entry valid bits, so the table is usable in
// the first cycle after reset, and loads signal_limit = 64, first_user_signal = 4.
`timescale 1ns / 1ps
module publish_subscribe_fanout_table_core import psft_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           action,
	input  logic [SIG_W-1:0]     signal,
	input  logic [PRIO_W-1:0]    priority_req,
	output logic                 strobe,
	output logic [PRIO_W-1:0]    subscriber_priority,
	output logic                 last,
	output logic                 error,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	state_t state_q, state_d;

	// Configuration registers.
	logic [LIMIT_W-1:0] limit_q;
	logic [SIG_W-1:0]   first_q;

	// The accepted command, held while the table is read and updated.
	action_t            act_q, act_d;
	logic [ADDR_W-1:0]  addr_q, addr_d;
	logic [PRIO_W-1:0]  prio_q, prio_d;

	// Working copy of the mask being walked during publish.
	logic [MASK_W-1:0]  mask_q, mask_d;

	// An entry that was never written reads as an empty mask.
	logic [SIGNAL_DEPTH-1:0] valid_q;
	logic                    set_valid;

	logic               strobe_q, strobe_d;
	logic [PRIO_W-1:0]  opri_q, opri_d;
	logic               last_q, last_d;
	logic               err_q, err_d;

	logic               ram_re, ram_we;
	logic [MASK_W-1:0]  ram_rdata;
	logic [MASK_W-1:0]  rd_mask;

	logic [MASK_W-1:0]  bit_mask;
	action_t            bit_op;
	bitop_res_t         bit_res;

	action_t            in_act;
	logic [ADDR_W-1:0]  in_addr;
	logic               bad_sig;

	assign in_act  = action_t'(action);
	assign in_addr = ADDR_W'(signal);
	assign bad_sig = (signal < first_q)
		|| ({1'b0, signal} >= limit_q)
		|| (32'(signal) >= 32'(SIGNAL_DEPTH));

	assign rd_mask = valid_q[addr_q] ? ram_rdata : '0;

	psft_ram #(
		.WIDTH(MASK_W),
		.DEPTH(SIGNAL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(bit_res.new_mask),
		.re   (ram_re),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	// The bit unit works on the freshly read mask in the read cycle and on the
	// working copy while a publish is walked.
	assign bit_mask = (state_q == ST_WALK) ? mask_q : rd_mask;
	assign bit_op   = (state_q == ST_WALK) ? ACT_PUB : act_q;

	psft_bitop u_bitop (
		.mask (bit_mask),
		.op   (bit_op),
		.index(prio_q),
		.res  (bit_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			strobe_q <= 1'b0;
			limit_q  <= LIMIT_RESET;
			first_q  <= FIRST_RESET;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			if (set_valid) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SIGNAL_LIMIT) begin
					limit_q <= cfg_data;
				end else if (cfg_index == REG_FIRST_USER) begin
					first_q <= cfg_data[SIG_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		act_q  <= act_d;
		addr_q <= addr_d;
		prio_q <= prio_d;
		mask_q <= mask_d;
		opri_q <= opri_d;
		last_q <= last_d;
		err_q  <= err_d;
	end

	always_comb begin
		state_d   = state_q;
		act_d     = act_q;
		addr_d    = addr_q;
		prio_d    = prio_q;
		mask_d    = mask_q;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		set_valid = 1'b0;
		strobe_d  = 1'b0;
		opri_d    = '0;
		last_d    = 1'b0;
		err_d     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && in_act != ACT_NONE) begin
					if (bad_sig || (in_act != ACT_PUB && priority_req == '0)) begin
						strobe_d = 1'b1;
						last_d   = 1'b1;
						err_d    = 1'b1;
					end else begin
						ram_re  = 1'b1;
						act_d   = in_act;
						addr_d  = in_addr;
						prio_d  = priority_req;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (act_q == ACT_PUB) begin
					if (bit_res.any) begin
						strobe_d = 1'b1;
						opri_d   = bit_res.top_idx;
						last_d   = bit_res.rest_zero;
						mask_d   = bit_res.new_mask;
						state_d  = bit_res.rest_zero ? ST_IDLE : ST_WALK;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					ram_we    = 1'b1;
					set_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_WALK: begin
				strobe_d = 1'b1;
				opri_d   = bit_res.top_idx;
				last_d   = bit_res.rest_zero;
				mask_d   = bit_res.new_mask;
				if (bit_res.rest_zero) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy                = (state_q != ST_IDLE);
	assign cfg_ready           = 1'b1;
	assign strobe              = strobe_q;
	assign subscriber_priority = opri_q;
	assign last                = last_q;
	assign error               = err_q;

endmodule

// ===== sv/psft_checker.sv =====
// Port-level checker for the fan-out table core and its bind statement.
`timescale 1ns / 1ps
`include "publish_subscribe_fanout_table_core_assert.svh"
module psft_checker import psft_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 busy,
	input logic                 strobe,
	input logic [PRIO_W-1:0]    subscriber_priority,
	input logic                 last,
	input logic                 error
);

	// A publish burst runs on consecutive cycles until its last word.
	`PSFT_ASSERT_NEXT(a_burst_unbroken, strobe && !last, strobe, "publish burst broken before last")

	// Priorities in a burst strictly fall.
	`PSFT_ASSERT_NEXT(a_burst_falls, strobe && !last, subscriber_priority < $past(subscriber_priority), "publish priorities not descending")

	// An error word stands alone and carries no priority.
	`PSFT_ASSERT_NOW(a_error_shape, strobe && error, last && subscriber_priority == '0, "error word malformed")

	// While a burst is still open the block cannot take a new command.
	`PSFT_ASSERT_NOW(a_busy_in_burst, strobe && !last, busy, "not busy during publish burst")

endmodule

bind publish_subscribe_fanout_table_core psft_checker u_psft_checker (.*);

// ===== sim/publish_subscribe_fanout_table_core_test.sv =====
// Self-checking testbench for the publish/subscribe fan-out table core.
`timescale 1ns / 1ps
module publish_subscribe_fanout_table_core_test;
	import psft_pkg::*;

	// The block has two registers; indexes above them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam int HALF_PERIOD   = 2;
	localparam int SETTLE_CYCLES = 6;    // covers a table write back after the last word
	localparam int GAP_CAP       = 20;
	localparam int PHASE_ITEMS   = 46;
	localparam int HOT_COUNT     = 3;
	localparam int DIRECTED_ROWS = 28;

	// How a command's expected words are formed: from the predictor, or typed in.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_QUIET,
		CHK_REJECT
	} check_mode_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic              last;
		logic              err;
	} result_word_t;

	typedef struct {
		bit                   is_cfg;
		action_t              act;
		logic [SIG_W-1:0]     sig;
		logic [PRIO_W-1:0]    prio;
		check_mode_t          chk;
		logic [CFG_IDX_W-1:0] idx;
		logic [LIMIT_W-1:0]   data;
	} stim_row_t;

	localparam result_word_t REJECT_WORD = '{prio: '0, last: 1'b1, err: 1'b1};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           action;
	logic [SIG_W-1:0]     signal;
	logic [PRIO_W-1:0]    priority_req;
	logic                 strobe;
	logic [PRIO_W-1:0]    subscriber_priority;
	logic                 last;
	logic                 error;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LIMIT_W-1:0]   cfg_data;

	publish_subscribe_fanout_table_core DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.action              (action),
		.signal              (signal),
		.priority_req        (priority_req),
		.strobe              (strobe),
		.subscriber_priority (subscriber_priority),
		.last                (last),
		.error               (error),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	// Our own copy of the block's state: the mask table and both registers.
	logic [MASK_W-1:0]  sub_masks [SIGNAL_DEPTH];
	logic [LIMIT_W-1:0] sig_limit;
	logic [SIG_W-1:0]   first_user;

	// Words the current command fans out to, and words still owed by the block.
	result_word_t fanout_words [$];
	result_word_t expected_words [$];

	// Set by the driver with each command word, read by the monitor on acceptance.
	check_mode_t row_check;
	int          sender_idle_pct;
	logic [SIG_W-1:0] hot_signals [HOT_COUNT];
	stim_row_t   directed_rows [DIRECTED_ROWS];

	int failures;
	int n_cmds;
	int n_directed;
	int n_sub_words;
	int n_err_words;
	int n_cfg_writes;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// The timeout allows far more than the slowest legal run: every command a
	// full 31-word publish plus the longest sender gap.
	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Works out what one accepted command word does to the table and which
	// words it must produce. Out-of-range signals and priority zero leave the
	// table alone; publish walks a snapshot of the mask from the top bit down.
	task automatic predict_command(input action_t act, input logic [SIG_W-1:0] sig,
			input logic [PRIO_W-1:0] prio);
		logic [MASK_W-1:0] snap;
		result_word_t      w;
		fanout_words.delete();
		if (act == ACT_NONE)
			return;
		if (sig < first_user || {1'b0, sig} >= sig_limit || int'(sig) >= SIGNAL_DEPTH) begin
			fanout_words.push_back(REJECT_WORD);
			return;
		end
		if (act == ACT_SUB || act == ACT_UNSUB) begin
			if (prio == '0) begin
				fanout_words.push_back(REJECT_WORD);
			end else if (act == ACT_SUB) begin
				sub_masks[sig][prio] = 1'b1;
			end else begin
				sub_masks[sig][prio] = 1'b0;
			end
			return;
		end
		snap = sub_masks[sig];
		for (int b = MASK_W - 1; b >= 0; b--) begin
			if (snap[b]) begin
				w.prio = PRIO_W'(b);
				w.last = ((snap & ((MASK_W'(1) << b) - MASK_W'(1))) == '0);
				w.err  = 1'b0;
				fanout_words.push_back(w);
			end
		end
	endtask

	// Everything is sampled at the rising edge, where the inputs driven at the
	// falling edge are stable and the outputs still show the previous cycle.
	// A result word at this edge always belongs to an earlier command, so the
	// comparison runs before the new command's words are queued.
	always @(posedge clk) begin : monitor
		result_word_t want;
		if (arst_n) begin
			if (strobe) begin
				if (error)
					n_err_words++;
				else
					n_sub_words++;
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: priority %0d last %0b error %0b",
						subscriber_priority, last, error);
					failures++;
				end else begin
					want = expected_words.pop_front();
					if (subscriber_priority !== want.prio) begin
						$error("subscriber_priority: expected %0d, got %0d",
							want.prio, subscriber_priority);
						failures++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						failures++;
					end
					if (error !== want.err) begin
						$error("error: expected %0b, got %0b", want.err, error);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				n_cfg_writes++;
				if (cfg_index == REG_SIGNAL_LIMIT)
					sig_limit = cfg_data;
				else if (cfg_index == REG_FIRST_USER)
					first_user = cfg_data[SIG_W-1:0];
			end
			if (start && !busy) begin
				n_cmds++;
				predict_command(action_t'(action), signal, priority_req);
				case (row_check)
					CHK_MODEL: begin
						foreach (fanout_words[i])
							expected_words.push_back(fanout_words[i]);
					end
					CHK_REJECT: begin
						expected_words.push_back(REJECT_WORD);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Sends one command word after a random gap and holds it until the block
	// takes it. While start is low the fields carry junk that must be ignored.
	task automatic send_command(input action_t act, input logic [SIG_W-1:0] sig,
			input logic [PRIO_W-1:0] prio, input check_mode_t chk);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		@(negedge clk);
		if (gap != 0) begin
			start        = 1'b0;
			action       = 2'($urandom);
			signal       = SIG_W'($urandom);
			priority_req = PRIO_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		action       = act;
		signal       = sig;
		priority_req = prio;
		row_check    = chk;
		start        = 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Stops sending and waits until every owed word has come, then lets a
	// table write back with no word of its own finish.
	task automatic settle_block();
		@(negedge clk);
		start = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [LIMIT_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic stim_row_t cmd_row(input action_t act, input int sig, input int prio,
			input check_mode_t chk);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.act    = act;
		r.sig    = SIG_W'(sig);
		r.prio   = PRIO_W'(prio);
		r.chk    = chk;
		r.idx    = REG_SIGNAL_LIMIT;
		r.data   = '0;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.act    = ACT_NONE;
		r.sig    = '0;
		r.prio   = '0;
		r.chk    = CHK_QUIET;
		r.idx    = idx;
		r.data   = LIMIT_W'(data);
		return r;
	endfunction

	// Random commands aim mostly at a few valid signals so that masks fill up
	// and publishes fan out to many subscribers; the rest is spread over every
	// signal, priority zero and the ignored action.
	task automatic send_random_command();
		int               r;
		action_t          act;
		logic [SIG_W-1:0] sig;
		logic [PRIO_W-1:0] prio;
		r = $urandom_range(99);
		if (r < 42)
			act = ACT_SUB;
		else if (r < 60)
			act = ACT_UNSUB;
		else if (r < 94)
			act = ACT_PUB;
		else
			act = ACT_NONE;
		if ($urandom_range(99) < 85)
			sig = hot_signals[$urandom_range(HOT_COUNT - 1)];
		else
			sig = SIG_W'($urandom);
		if ($urandom_range(99) < 6)
			prio = '0;
		else
			prio = PRIO_W'($urandom_range(MASK_W - 1, 1));
		send_command(act, sig, prio, CHK_MODEL);
	endtask

	task automatic pick_hot_signals();
		int lo;
		int hi;
		lo = first_user;
		hi = (int'(sig_limit) < SIGNAL_DEPTH) ? int'(sig_limit) - 1 : SIGNAL_DEPTH - 1;
		foreach (hot_signals[i])
			hot_signals[i] = (lo <= hi) ? SIG_W'($urandom_range(hi, lo)) : SIG_W'($urandom);
	endtask

	initial begin
		foreach (sub_masks[i])
			sub_masks[i] = '0;
		sig_limit       = LIMIT_RESET;
		first_user      = FIRST_RESET;
		failures        = 0;
		n_cmds          = 0;
		n_directed      = 0;
		n_sub_words     = 0;
		n_err_words     = 0;
		n_cfg_writes    = 0;
		row_check       = CHK_MODEL;
		sender_idle_pct = 20;
		arst_n          = 1'b0;
		start           = 1'b0;
		action          = ACT_NONE;
		signal          = '0;
		priority_req    = '0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_SIGNAL_LIMIT;
		cfg_data        = '0;

		// Directed part: the table starts empty with signals 4 to 63 valid.
		// Quiet and reject rows are typed in; publishes of a known mask go
		// through the predictor.
		directed_rows = '{
			cmd_row(ACT_PUB,   4,  0,  CHK_QUIET),   // empty table after reset
			cmd_row(ACT_SUB,   4,  31, CHK_QUIET),
			cmd_row(ACT_SUB,   4,  1,  CHK_QUIET),
			cmd_row(ACT_SUB,   63, 31, CHK_QUIET),   // top signal is valid
			cmd_row(ACT_PUB,   4,  0,  CHK_MODEL),   // highest and lowest priority
			cmd_row(ACT_PUB,   63, 17, CHK_MODEL),   // single subscriber, priority ignored
			cmd_row(ACT_SUB,   4,  0,  CHK_REJECT),  // priority zero
			cmd_row(ACT_UNSUB, 4,  0,  CHK_REJECT),
			cmd_row(ACT_SUB,   3,  5,  CHK_REJECT),  // just below the first user signal
			cmd_row(ACT_PUB,   0,  0,  CHK_REJECT),
			cmd_row(ACT_NONE,  4,  7,  CHK_QUIET),   // ignored action
			cmd_row(ACT_NONE,  0,  0,  CHK_QUIET),   // ignored even when out of range
			cmd_row(ACT_UNSUB, 4,  31, CHK_QUIET),
			cmd_row(ACT_PUB,   4,  0,  CHK_MODEL),
			cmd_row(ACT_UNSUB, 4,  9,  CHK_QUIET),   // bit that was never set
			cmd_row(ACT_PUB,   4,  0,  CHK_MODEL),
			cfg_row(REG_SIGNAL_LIMIT, 0),            // every signal out of range
			cmd_row(ACT_PUB,   4,  0,  CHK_REJECT),
			cfg_row(REG_SIGNAL_LIMIT, 127),
			cfg_row(REG_FIRST_USER, 127),            // only the low six bits count
			cmd_row(ACT_PUB,   63, 0,  CHK_MODEL),
			cmd_row(ACT_SUB,   62, 2,  CHK_REJECT),
			cfg_row(REG_FIRST_USER, 64),             // reads as zero
			cmd_row(ACT_SUB,   0,  16, CHK_QUIET),
			cmd_row(ACT_PUB,   0,  0,  CHK_MODEL),
			cfg_row(REG_SPARE_HI, 1),                // writes to spare indexes are dropped
			cfg_row(REG_SPARE_LO, 0),
			cmd_row(ACT_PUB,   0,  0,  CHK_MODEL)
		};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle_block();
				write_register(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_command(directed_rows[i].act, directed_rows[i].sig,
					directed_rows[i].prio, directed_rows[i].chk);
			end
		end
		n_directed = n_cmds;

		// Random part in three phases, each with its own register setting and
		// sender gap rate: reset setting, a narrow random window, then the
		// widest limit. Masks carry over from one phase to the next.
		for (int phase = 0; phase < 3; phase++) begin
			settle_block();
			case (phase)
				0: begin
					sender_idle_pct = 32;
					write_register(REG_SIGNAL_LIMIT, LIMIT_RESET);
					write_register(REG_FIRST_USER, LIMIT_W'(FIRST_RESET));
				end
				1: begin
					sender_idle_pct = 45;
					write_register(REG_SIGNAL_LIMIT, LIMIT_W'($urandom_range(63, 24)));
					write_register(REG_FIRST_USER, LIMIT_W'($urandom_range(12, 1)));
				end
				default: begin
					sender_idle_pct = 0;
					write_register(REG_SIGNAL_LIMIT, 7'd127);
					write_register(REG_FIRST_USER, LIMIT_W'($urandom_range(3, 0)));
				end
			endcase
			pick_hot_signals();
			repeat (PHASE_ITEMS) send_random_command();
		end

		settle_block();
		$display("Ran %0d command words (%0d directed) and %0d register writes.",
			n_cmds, n_directed, n_cfg_writes);
		$display("Checked %0d subscriber words and %0d error words over three settings.",
			n_sub_words, n_err_words);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/psft_pkg.sv
sv/psft_ram.sv
sv/psft_bitop.sv
sv/publish_subscribe_fanout_table_core.sv
sv/psft_checker.sv
sim/publish_subscribe_fanout_table_core_test.sv
